/* rtl/core/small_matrix_inverse_macros.svh */
// Assertion macros for the small matrix inverse block.
`ifndef SMALL_MATRIX_INVERSE_MACROS_SVH
`define SMALL_MATRIX_INVERSE_MACROS_SVH

`ifndef SYNTHESIS

// Checks a property on every clock edge outside reset.
`define SMI_ASSERT(label, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("small_matrix_inverse: assertion failed");

// Checks that a condition holds in the cycle after a trigger.
`define SMI_ASSERT_NEXT(label, trig, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cons)) \
        else $error("small_matrix_inverse: assertion failed");

`else

`define SMI_ASSERT(label, prop)
`define SMI_ASSERT_NEXT(label, trig, cons)

`endif

`endif

/* rtl/core/smi_pkg.sv */
// Package with types, constants and helper functions of the small matrix inverse.
`timescale 1ns / 1ps

package smi_pkg;

    localparam int DIM_MAX = 4;
    localparam int QW      = 48;
    localparam int QUO_W   = 33;

    localparam logic [QUO_W-1:0] QUO_POS_MAX = 33'h07FFFFFFF;
    localparam logic [QUO_W-1:0] QUO_NEG_MAX = 33'h080000000;
    localparam logic [5:0]       DIV_STEPS   = 6'd33;

    // Which product of the minor evaluation is in flight.
    localparam logic [1:0] SUB_P1    = 2'd0;
    localparam logic [1:0] SUB_P2    = 2'd1;
    localparam logic [1:0] SUB_OUTER = 2'd2;
    localparam logic [1:0] SUB_DET   = 2'd3;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_CF_START,
        ST_M1,
        ST_RD_B,
        ST_RD_A,
        ST_MUL_HI,
        ST_MUL_LO,
        ST_SUM,
        ST_POST,
        ST_NEG,
        ST_SIGN,
        ST_DET_DONE,
        ST_OUT_START,
        ST_DIV_INIT,
        ST_DIV,
        ST_DIV_DONE,
        ST_OUT
    } state_t;

    typedef enum logic [1:0] {
        PH_DET2,
        PH_DETX,
        PH_OUT
    } phase_t;

    typedef struct packed {
        logic                 clamp;
        logic signed [QW-1:0] val;
    } sat_t;

    // Clamps a wide signed value to the Q32.16 range.
    function automatic sat_t sat48(input logic signed [65:0] x);
        sat_t r;
        if (x > 66'sh00000_7FFF_FFFF_FFFF)
        begin
            r.clamp = 1'b1;
            r.val   = {1'b0, {(QW-1){1'b1}}};
        end
        else if (x < -66'sh00000_8000_0000_0000)
        begin
            r.clamp = 1'b1;
            r.val   = {1'b1, {(QW-1){1'b0}}};
        end
        else
        begin
            r.clamp = 1'b0;
            r.val   = x[QW-1:0];
        end
        return r;
    endfunction

    // k-th index of 0, 1, 2, ... with one index left out.
    function automatic logic [1:0] skip_idx(input logic [1:0] k, input logic [1:0] s);
        return (k >= s) ? k + 2'd1 : k;
    endfunction

endpackage

/* rtl/core/small_matrix_inverse.sv */
// Top level of the small matrix inverse: element store, sequencer, multiplier and divider.
`timescale 1ns / 1ps

// Loads a 2x2, 3x3 or 4x4 matrix of Q16.16 values one element per request and, on the
// request marked tlast, returns its inverse in row-major order, one element per request.
// All products go through one multiplier pass (two reads of the element store, high and
// low partial products, sum and saturation, accumulate), and each inverse element of a
// non-singular matrix goes through a 33-step restoring divider unless the quotient is
// already known to overflow. The block takes no new element while an inversion is
// running.
`include "small_matrix_inverse_macros.svh"

module small_matrix_inverse
    import smi_pkg::*;
#(
    parameter int MAX_DIM = DIM_MAX
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_wdata,   // matrix_size
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,     // row_index[1:0], col_index[3:2], element_value[35:4]
    input  logic        s_tlast,     // last_element
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,     // out_row[1:0], out_col[3:2], out_value[35:4]
    output logic [1:0]  m_tuser,     // is_singular[0], saturated[1]
    output logic        m_tlast      // last_result
);

    localparam int DEPTH  = MAX_DIM * MAX_DIM;
    localparam int ADDR_W = $clog2(DEPTH);

    function automatic logic [ADDR_W-1:0] eaddr(input logic [1:0] r, input logic [1:0] c);
        logic [5:0] t;
        t = 6'(r) * 6'(MAX_DIM) + 6'(c);
        return t[ADDR_W-1:0];
    endfunction

    state_t state_reg, state_next;
    phase_t phase_reg, phase_next;

    logic signed [31:0] mem [DEPTH];
    logic signed [31:0] rd_data_reg;
    logic [ADDR_W-1:0]  rd_addr;
    logic               rd_en;

    logic [2:0] size_reg;
    logic [2:0] n_reg, n_next, n_cur;
    logic [1:0] nm1;
    logic [1:0] skip_r_reg, skip_r_next, skip_c_reg, skip_c_next;
    logic [1:0] mdim_reg, mdim_next;
    logic [1:0] j_reg, j_next, jd_reg, jd_next, sub_reg, sub_next;
    logic [1:0] orow_reg, orow_next, ocol_reg, ocol_next;
    logic       clamp_reg, clamp_next, det_clamp_reg, det_clamp_next;

    logic signed [QW-1:0] opb_reg, opb_next, q_reg, q_next, p1_reg, p1_next;
    logic signed [QW-1:0] d2_reg, d2_next, acc_reg, acc_next, cof_reg, cof_next;
    logic signed [QW-1:0] det_reg, det_next;
    logic signed [64:0]   hi_reg, lo_reg, prod;
    logic signed [64:0]   mul_a, mul_b;

    logic [QW-1:0]    rem_reg, rem_next, ud_reg, ud_next;
    logic [QUO_W-1:0] nbits_reg, nbits_next, quo_reg, quo_next;
    logic [5:0]       dcnt_reg, dcnt_next;
    logic             dneg_reg, dneg_next, dovf_reg, dovf_next;

    logic [1:0]         out_row_reg, out_row_next, out_col_reg, out_col_next;
    logic signed [31:0] out_val_reg, out_val_next;
    logic               out_sing_reg, out_sing_next, out_sat_reg, out_sat_next;
    logic               out_last_reg, out_last_next;

    logic [1:0] in_row, in_col;
    logic       in_acc, out_acc;

    logic [1:0] rbase, r_a, r_b, c0, c1, r0, cj;
    logic [QW-1:0] cof_abs, det_abs;
    logic [63:0]   un;
    logic          ovf;
    logic [QW:0]   trial;
    logic          trial_ge;
    logic          last_pos;
    sat_t          s_sum, s_p, s_neg, s_sign;
    logic signed [65:0] sum_wide;

    assign in_row  = s_tdata[1:0];
    assign in_col  = s_tdata[3:2];
    assign in_acc  = s_tvalid && s_tready;
    assign out_acc = m_tvalid && m_tready;

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = (state_reg == ST_OUT);
    assign m_tdata  = {4'd0, out_val_reg, out_col_reg, out_row_reg};
    assign m_tuser  = {out_sat_reg, out_sing_reg};
    assign m_tlast  = out_last_reg;

    always_comb
    begin
        if (size_reg < 3'd2)
        begin
            n_cur = 3'd2;
        end
        else if (size_reg > 3'(MAX_DIM))
        begin
            n_cur = 3'(MAX_DIM);
        end
        else
        begin
            n_cur = size_reg;
        end
    end

    assign nm1 = 2'(n_reg - 3'd1);

    // Row and column lists of the current minor; the inner 2x2 skips column j.
    assign rbase = (mdim_reg == 2'd3) ? 2'd1 : 2'd0;
    assign r0    = skip_idx(2'd0, skip_r_reg);
    assign r_a   = skip_idx(rbase, skip_r_reg);
    assign r_b   = skip_idx(rbase + 2'd1, skip_r_reg);
    assign c0    = skip_idx(skip_idx(2'd0, j_reg), skip_c_reg);
    assign c1    = skip_idx(skip_idx(2'd1, j_reg), skip_c_reg);
    assign cj    = skip_idx(j_reg, skip_c_reg);

    always_comb
    begin
        rd_en   = 1'b0;
        rd_addr = eaddr(r0, skip_idx(2'd0, skip_c_reg));
        case (state_reg)
            ST_CF_START:
            begin
                rd_en = 1'b1;
            end
            ST_RD_B:
            begin
                rd_en   = 1'b1;
                rd_addr = (sub_reg == SUB_P1) ? eaddr(r_b, c1) : eaddr(r_b, c0);
            end
            ST_RD_A:
            begin
                rd_en = 1'b1;
                case (sub_reg)
                    SUB_P1:    rd_addr = eaddr(r_a, c0);
                    SUB_P2:    rd_addr = eaddr(r_a, c1);
                    SUB_OUTER: rd_addr = eaddr(r0, cj);
                    default:   rd_addr = eaddr(2'd0, jd_reg);
                endcase
            end
            default:
            begin
                rd_en = 1'b0;
            end
        endcase
    end

    // Shared multiplier: element times the high or the low part of the 48-bit operand.
    assign mul_a = 65'(rd_data_reg);
    assign mul_b = (state_reg == ST_MUL_HI) ? 65'($signed(opb_reg[QW-1:16]))
                                            : $signed({49'd0, opb_reg[15:0]});
    assign prod  = mul_a * mul_b;

    assign sum_wide = 66'(hi_reg) + 66'($signed(lo_reg[64:16]));
    assign s_sum    = sat48(sum_wide);
    always_comb
    begin
        case (sub_reg)
            SUB_P2:    s_p = sat48(66'(p1_reg) - 66'(q_reg));
            SUB_OUTER: s_p = sat48(66'(acc_reg) + 66'(q_reg));
            default:   s_p = sat48(66'(det_reg) + 66'(q_reg));
        endcase
    end
    assign s_neg  = sat48(-66'(d2_reg));
    assign s_sign = ((skip_r_reg[0] ^ skip_c_reg[0]) == 1'b1) ? sat48(-66'(acc_reg))
                                                              : sat48(66'(acc_reg));

    assign cof_abs  = cof_reg[QW-1] ? (~cof_reg + 1'b1) : cof_reg;
    assign det_abs  = det_reg[QW-1] ? (~det_reg + 1'b1) : det_reg;
    assign un       = {cof_abs, 16'd0};
    assign ovf      = {17'd0, un[63:33]} >= det_abs;
    assign trial    = {rem_reg, nbits_reg[QUO_W-1]};
    assign trial_ge = trial >= {1'b0, ud_reg};
    assign last_pos = (orow_reg == nm1) && (ocol_reg == nm1);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_acc && s_tlast)
                begin
                    state_next = ST_CF_START;
                end
            end
            ST_CF_START:  state_next = (mdim_reg == 2'd1) ? ST_M1 : ST_RD_B;
            ST_M1:        state_next = ST_SIGN;
            ST_RD_B:      state_next = ST_RD_A;
            ST_RD_A:      state_next = ST_MUL_HI;
            ST_MUL_HI:    state_next = ST_MUL_LO;
            ST_MUL_LO:    state_next = ST_SUM;
            ST_SUM:       state_next = ST_POST;
            ST_POST:
            begin
                case (sub_reg)
                    SUB_P1:
                    begin
                        state_next = ST_RD_B;
                    end
                    SUB_P2:
                    begin
                        if (mdim_reg == 2'd2)
                        begin
                            state_next = ST_SIGN;
                        end
                        else
                        begin
                            state_next = j_reg[0] ? ST_NEG : ST_RD_B;
                        end
                    end
                    SUB_OUTER:
                    begin
                        state_next = (j_reg == 2'd2) ? ST_SIGN : ST_RD_B;
                    end
                    default:
                    begin
                        state_next = (jd_reg == nm1) ? ST_DET_DONE : ST_CF_START;
                    end
                endcase
            end
            ST_NEG:       state_next = ST_RD_B;
            ST_SIGN:
            begin
                case (phase_reg)
                    PH_DET2: state_next = ST_DET_DONE;
                    PH_DETX: state_next = ST_RD_B;
                    default: state_next = ST_DIV_INIT;
                endcase
            end
            ST_DET_DONE:  state_next = ST_OUT_START;
            ST_OUT_START: state_next = (det_reg == '0) ? ST_OUT : ST_CF_START;
            ST_DIV_INIT:  state_next = ovf ? ST_DIV_DONE : ST_DIV;
            ST_DIV:       state_next = (dcnt_reg == 6'd1) ? ST_DIV_DONE : ST_DIV;
            ST_DIV_DONE:  state_next = ST_OUT;
            ST_OUT:
            begin
                if (m_tready)
                begin
                    state_next = out_last_reg ? ST_IDLE : ST_OUT_START;
                end
            end
            default:      state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        phase_next     = phase_reg;
        n_next         = n_reg;
        skip_r_next    = skip_r_reg;
        skip_c_next    = skip_c_reg;
        mdim_next      = mdim_reg;
        j_next         = j_reg;
        jd_next        = jd_reg;
        sub_next       = sub_reg;
        orow_next      = orow_reg;
        ocol_next      = ocol_reg;
        clamp_next     = clamp_reg;
        det_clamp_next = det_clamp_reg;
        opb_next       = opb_reg;
        q_next         = q_reg;
        p1_next        = p1_reg;
        d2_next        = d2_reg;
        acc_next       = acc_reg;
        cof_next       = cof_reg;
        det_next       = det_reg;
        rem_next       = rem_reg;
        ud_next        = ud_reg;
        nbits_next     = nbits_reg;
        quo_next       = quo_reg;
        dcnt_next      = dcnt_reg;
        dneg_next      = dneg_reg;
        dovf_next      = dovf_reg;
        out_row_next   = out_row_reg;
        out_col_next   = out_col_reg;
        out_val_next   = out_val_reg;
        out_sing_next  = out_sing_reg;
        out_sat_next   = out_sat_reg;
        out_last_next  = out_last_reg;
        case (state_reg)
            ST_IDLE:
            begin
                n_next     = n_cur;
                clamp_next = 1'b0;
                det_next   = '0;
                jd_next    = 2'd0;
                if (n_cur == 3'd2)
                begin
                    // A 2x2 determinant is the 2x2 minor with nothing left out.
                    phase_next  = PH_DET2;
                    skip_r_next = 2'd3;
                    skip_c_next = 2'd3;
                    mdim_next   = 2'd2;
                end
                else
                begin
                    phase_next  = PH_DETX;
                    skip_r_next = 2'd0;
                    skip_c_next = 2'd0;
                    mdim_next   = 2'(n_cur - 3'd1);
                end
            end
            ST_CF_START:
            begin
                acc_next = '0;
                sub_next = SUB_P1;
                j_next   = (mdim_reg == 2'd3) ? 2'd0 : 2'd3;
            end
            ST_M1:
            begin
                acc_next = QW'(rd_data_reg);
            end
            ST_RD_A:
            begin
                case (sub_reg)
                    SUB_P1, SUB_P2: opb_next = QW'(rd_data_reg);
                    SUB_OUTER:      opb_next = d2_reg;
                    default:        opb_next = cof_reg;
                endcase
            end
            ST_SUM:
            begin
                q_next     = s_sum.val;
                clamp_next = clamp_reg | s_sum.clamp;
            end
            ST_POST:
            begin
                case (sub_reg)
                    SUB_P1:
                    begin
                        p1_next  = q_reg;
                        sub_next = SUB_P2;
                    end
                    SUB_P2:
                    begin
                        clamp_next = clamp_reg | s_p.clamp;
                        if (mdim_reg == 2'd2)
                        begin
                            acc_next = s_p.val;
                        end
                        else
                        begin
                            d2_next  = s_p.val;
                            sub_next = SUB_OUTER;
                        end
                    end
                    SUB_OUTER:
                    begin
                        clamp_next = clamp_reg | s_p.clamp;
                        acc_next   = s_p.val;
                        sub_next   = SUB_P1;
                        j_next     = j_reg + 2'd1;
                    end
                    default:
                    begin
                        clamp_next  = clamp_reg | s_p.clamp;
                        det_next    = s_p.val;
                        jd_next     = jd_reg + 2'd1;
                        skip_c_next = jd_reg + 2'd1;
                    end
                endcase
            end
            ST_NEG:
            begin
                clamp_next = clamp_reg | s_neg.clamp;
                d2_next    = s_neg.val;
            end
            ST_SIGN:
            begin
                clamp_next = clamp_reg | s_sign.clamp;
                cof_next   = s_sign.val;
                sub_next   = SUB_DET;
                if (phase_reg == PH_DET2)
                begin
                    det_next = acc_reg;
                end
            end
            ST_DET_DONE:
            begin
                det_clamp_next = clamp_reg;
                phase_next     = PH_OUT;
                orow_next      = 2'd0;
                ocol_next      = 2'd0;
                mdim_next      = nm1;
            end
            ST_OUT_START:
            begin
                // The cofactor of the transposed position gives this inverse element.
                clamp_next    = 1'b0;
                skip_r_next   = ocol_reg;
                skip_c_next   = orow_reg;
                out_row_next  = orow_reg;
                out_col_next  = ocol_reg;
                out_last_next = last_pos;
                out_val_next  = '0;
                out_sing_next = (det_reg == '0);
                out_sat_next  = 1'b0;
            end
            ST_DIV_INIT:
            begin
                ud_next    = det_abs;
                rem_next   = QW'(un[63:33]);
                nbits_next = un[32:0];
                quo_next   = '0;
                dcnt_next  = DIV_STEPS;
                dneg_next  = cof_reg[QW-1] ^ det_reg[QW-1];
                dovf_next  = ovf;
            end
            ST_DIV:
            begin
                rem_next   = trial_ge ? QW'(trial - {1'b0, ud_reg}) : trial[QW-1:0];
                quo_next   = {quo_reg[QUO_W-2:0], trial_ge};
                nbits_next = {nbits_reg[QUO_W-2:0], 1'b0};
                dcnt_next  = dcnt_reg - 6'd1;
            end
            ST_DIV_DONE:
            begin
                if (dneg_reg)
                begin
                    if (dovf_reg || quo_reg > QUO_NEG_MAX)
                    begin
                        out_val_next = 32'sh8000_0000;
                        out_sat_next = 1'b1;
                    end
                    else
                    begin
                        out_val_next = -$signed(quo_reg[31:0]);
                        out_sat_next = det_clamp_reg | clamp_reg;
                    end
                end
                else
                begin
                    if (dovf_reg || quo_reg > QUO_POS_MAX)
                    begin
                        out_val_next = 32'sh7FFF_FFFF;
                        out_sat_next = 1'b1;
                    end
                    else
                    begin
                        out_val_next = $signed(quo_reg[31:0]);
                        out_sat_next = det_clamp_reg | clamp_reg;
                    end
                end
            end
            ST_OUT:
            begin
                if (m_tready)
                begin
                    if (ocol_reg == nm1)
                    begin
                        ocol_next = 2'd0;
                        orow_next = orow_reg + 2'd1;
                    end
                    else
                    begin
                        ocol_next = ocol_reg + 2'd1;
                    end
                end
            end
            default:
            begin
                q_next = q_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (in_acc && (3'(in_row) < 3'(MAX_DIM)) && (3'(in_col) < 3'(MAX_DIM)))
        begin
            mem[eaddr(in_row, in_col)] <= $signed(s_tdata[35:4]);
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        hi_reg       <= (state_reg == ST_MUL_HI) ? prod : hi_reg;
        lo_reg       <= (state_reg == ST_MUL_LO) ? prod : lo_reg;
        opb_reg      <= opb_next;
        q_reg        <= q_next;
        p1_reg       <= p1_next;
        d2_reg       <= d2_next;
        acc_reg      <= acc_next;
        cof_reg      <= cof_next;
        det_reg      <= det_next;
        rem_reg      <= rem_next;
        ud_reg       <= ud_next;
        nbits_reg    <= nbits_next;
        quo_reg      <= quo_next;
        dneg_reg     <= dneg_next;
        dovf_reg     <= dovf_next;
        out_row_reg  <= out_row_next;
        out_col_reg  <= out_col_next;
        out_val_reg  <= out_val_next;
        out_sing_reg <= out_sing_next;
        out_sat_reg  <= out_sat_next;
        out_last_reg <= out_last_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            phase_reg     <= PH_DET2;
            size_reg      <= 3'd4;
            n_reg         <= 3'd2;
            skip_r_reg    <= 2'd0;
            skip_c_reg    <= 2'd0;
            mdim_reg      <= 2'd1;
            j_reg         <= 2'd0;
            jd_reg        <= 2'd0;
            sub_reg       <= SUB_P1;
            orow_reg      <= 2'd0;
            ocol_reg      <= 2'd0;
            clamp_reg     <= 1'b0;
            det_clamp_reg <= 1'b0;
            dcnt_reg      <= 6'd0;
        end
        else
        begin
            state_reg     <= state_next;
            phase_reg     <= phase_next;
            size_reg      <= cfg_we ? cfg_wdata : size_reg;
            n_reg         <= n_next;
            skip_r_reg    <= skip_r_next;
            skip_c_reg    <= skip_c_next;
            mdim_reg      <= mdim_next;
            j_reg         <= j_next;
            jd_reg        <= jd_next;
            sub_reg       <= sub_next;
            orow_reg      <= orow_next;
            ocol_reg      <= ocol_next;
            clamp_reg     <= clamp_next;
            det_clamp_reg <= det_clamp_next;
            dcnt_reg      <= dcnt_next;
        end
    end

    `SMI_ASSERT(a_busy_excl, !(s_tready && m_tvalid))
    `SMI_ASSERT(a_singular_zero, !(m_tvalid && m_tuser[0]) || (m_tdata[35:4] == '0 && !m_tuser[1]))
    `SMI_ASSERT_NEXT(a_start_busy, in_acc && s_tlast, !s_tready)
    `SMI_ASSERT_NEXT(a_last_idle, out_acc && m_tlast, s_tready)

endmodule

/* bench/tb_top.sv */
// Self-checking testbench of the small matrix inverse block.
`timescale 1ns / 1ps

module tb_top
    import smi_pkg::*;
();

    localparam longint Q_MAX = 64'sh0000_7FFF_FFFF_FFFF;
    localparam longint Q_MIN = -Q_MAX - 1;
    localparam int     WATCH_LIMIT = 20000;

    typedef struct {
        logic [1:0]  row;
        logic [1:0]  col;
        logic [31:0] val;
        logic        last;
    } elem_req_t;

    typedef struct {
        logic [1:0]  row;
        logic [1:0]  col;
        logic [31:0] val;
        logic        singular;
        logic        sat;
        logic        last;
    } inv_elem_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [2:0]  cfg_wdata;
    logic        s_tvalid;
    logic        s_tready;
    logic [39:0] s_tdata;
    logic        s_tlast;
    logic        m_tvalid;
    logic        m_tready;
    logic [39:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        m_tlast;

    elem_req_t  load_q[$];
    inv_elem_t  inverse_q[$];
    logic [31:0] shadow_mat[4][4];
    logic [15:0] written_mask;
    logic [2:0]  size_reg;
    logic        clamp_seen;
    int          fail_count;
    int          req_count;
    int          inv_count;
    int          result_count;
    int          singular_count;
    int          sat_count;
    int          idle_cycles;
    logic        calm;
    logic        long_hold;

    small_matrix_inverse i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    always
    begin
        clk = 1'b1;
        #4;
        clk = 1'b0;
        #4;
    end

    // Q32.16 arithmetic with clamping, as the block does it.
    function automatic longint clamp48(input longint v);
        if (v > Q_MAX)
        begin
            clamp_seen = 1'b1;
            return Q_MAX;
        end
        if (v < Q_MIN)
        begin
            clamp_seen = 1'b1;
            return Q_MIN;
        end
        return v;
    endfunction

    function automatic longint fix_mul(input longint a, input longint b);
        longint bh;
        longint bl;
        bh = b >>> 16;
        bl = b & 64'hFFFF;
        return clamp48(a * bh + ((a * bl) >>> 16));
    endfunction

    function automatic longint entry(input logic [1:0] r, input logic [1:0] c);
        return longint'($signed(shadow_mat[r][c]));
    endfunction

    // Rows and columns of a submatrix are packed two bits each, first in the low bits.
    function automatic longint sub_det(input int n, input logic [7:0] rs, input logic [7:0] cs);
        longint     acc;
        longint     cof;
        logic [7:0] sub;
        int         m;
        acc = 0;
        if (n <= 1)
            return entry(rs[1:0], cs[1:0]);
        if (n == 2)
            return clamp48(fix_mul(entry(rs[1:0], cs[1:0]), entry(rs[3:2], cs[3:2])) -
                           fix_mul(entry(rs[1:0], cs[3:2]), entry(rs[3:2], cs[1:0])));
        for (int j = 0; j < n; j++)
        begin
            sub = '0;
            m = 0;
            for (int k = 0; k < n; k++)
                if (k != j)
                begin
                    sub[2*m +: 2] = cs[2*k +: 2];
                    m++;
                end
            cof = sub_det(n - 1, rs >> 2, sub);
            if (j % 2 == 1)
                cof = clamp48(-cof);
            acc = clamp48(acc + fix_mul(entry(rs[1:0], cs[2*j +: 2]), cof));
        end
        return acc;
    endfunction

    function automatic longint signed_minor(input int n, input int r, input int c);
        logic [7:0] rs;
        logic [7:0] cs;
        int         a;
        int         b;
        longint     mnr;
        rs = '0;
        cs = '0;
        a = 0;
        b = 0;
        for (int i = 0; i < n; i++)
        begin
            if (i != r)
            begin
                rs[2*a +: 2] = 2'(i);
                a++;
            end
            if (i != c)
            begin
                cs[2*b +: 2] = 2'(i);
                b++;
            end
        end
        mnr = sub_det(n - 1, rs, cs);
        if ((r + c) % 2 == 1)
            mnr = clamp48(-mnr);
        return mnr;
    endfunction

    // Stores an accepted element and, on the last one, queues the whole inverse.
    task automatic predict_inverse(input logic [39:0] data, input logic last);
        int               n;
        longint           det;
        logic             det_clamp;
        longint           cof;
        longint           num;
        longint unsigned  un;
        longint unsigned  ud;
        longint unsigned  q;
        logic             neg;
        inv_elem_t        e;
        shadow_mat[data[1:0]][data[3:2]] = data[35:4];
        if (!last)
            return;
        n = (size_reg < 2) ? 2 : (size_reg > DIM_MAX) ? DIM_MAX : int'(size_reg);
        clamp_seen = 1'b0;
        det = sub_det(n, 8'b11_10_01_00, 8'b11_10_01_00);
        det_clamp = clamp_seen;
        inv_count++;
        for (int r = 0; r < n; r++)
            for (int c = 0; c < n; c++)
            begin
                e.row = 2'(r);
                e.col = 2'(c);
                e.val = '0;
                e.sat = 1'b0;
                e.singular = (det == 0);
                e.last = (r == n - 1) && (c == n - 1);
                if (det != 0)
                begin
                    clamp_seen = 1'b0;
                    cof = signed_minor(n, c, r);
                    e.sat = det_clamp || clamp_seen;
                    num = cof * 65536;
                    neg = (num < 0) != (det < 0);
                    un = (num < 0) ? 64'd0 - num : num;
                    ud = (det < 0) ? 64'd0 - det : det;
                    q = un / ud;
                    if (!neg)
                    begin
                        if (q > 64'h7FFF_FFFF)
                        begin
                            q = 64'h7FFF_FFFF;
                            e.sat = 1'b1;
                        end
                        e.val = q[31:0];
                    end
                    else
                    begin
                        if (q > 64'h8000_0000)
                        begin
                            q = 64'h8000_0000;
                            e.sat = 1'b1;
                        end
                        e.val = 32'(0 - q);
                    end
                end
                inverse_q.push_back(e);
            end
    endtask

    // Sender: one request at a time from the load queue, with random gaps.
    int        send_gap;
    elem_req_t nxt;
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            s_tlast  <= 1'b0;
            send_gap = 0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                predict_inverse(s_tdata, s_tlast);
                req_count++;
            end
            if (!(s_tvalid && !s_tready))
            begin
                if (send_gap > 0)
                begin
                    send_gap--;
                    s_tvalid <= 1'b0;
                end
                else if (load_q.size() > 0)
                begin
                    nxt = load_q.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= {4'b0, nxt.val, nxt.col, nxt.row};
                    s_tlast  <= nxt.last;
                    send_gap = calm ? 0 : $urandom_range(0, 3);
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    // Receiver: compares each result with the oldest expected inverse element.
    int        recv_wait;
    inv_elem_t want;
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready <= 1'b0;
            recv_wait = 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                result_count++;
                if (inverse_q.size() == 0)
                begin
                    $error("unexpected result row %0d col %0d", m_tdata[1:0], m_tdata[3:2]);
                    fail_count++;
                end
                else
                begin
                    want = inverse_q.pop_front();
                    if (m_tuser[0])
                        singular_count++;
                    if (m_tuser[1])
                        sat_count++;
                    if (m_tdata[1:0] !== want.row)
                    begin
                        $error("out_row: expected %0d, got %0d", want.row, m_tdata[1:0]);
                        fail_count++;
                    end
                    if (m_tdata[3:2] !== want.col)
                    begin
                        $error("out_col: expected %0d, got %0d", want.col, m_tdata[3:2]);
                        fail_count++;
                    end
                    if (m_tdata[35:4] !== want.val)
                    begin
                        $error("out_value: expected %h, got %h", want.val, m_tdata[35:4]);
                        fail_count++;
                    end
                    if (m_tuser[0] !== want.singular)
                    begin
                        $error("is_singular: expected %b, got %b", want.singular, m_tuser[0]);
                        fail_count++;
                    end
                    if (m_tuser[1] !== want.sat)
                    begin
                        $error("saturated: expected %b, got %b", want.sat, m_tuser[1]);
                        fail_count++;
                    end
                    if (m_tlast !== want.last)
                    begin
                        $error("last_result: expected %b, got %b", want.last, m_tlast);
                        fail_count++;
                    end
                end
                if (long_hold)
                begin
                    recv_wait = 400;
                    long_hold = 1'b0;
                end
                else
                    recv_wait = calm ? 0 : $urandom_range(0, 3);
            end
            if (recv_wait > 0)
            begin
                recv_wait--;
                m_tready <= 1'b0;
            end
            else
                m_tready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !rst_n)
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCH_LIMIT)
        begin
            $display("timeout with %0d results outstanding", inverse_q.size());
            $display("*** FAILED ***");
            $finish;
        end
    end

    task automatic push_elem(input int r, input int c, input logic [31:0] v, input logic last);
        elem_req_t it;
        it.row = 2'(r);
        it.col = 2'(c);
        it.val = v;
        it.last = last;
        load_q.push_back(it);
        written_mask[r*4 + c] = 1'b1;
    endtask

    function automatic logic [31:0] pick_value(input int kind, input int r, input int c);
        case (kind)
            0: return (r == c) ? (($urandom_range(0, 1) ? 32'd1 : -32'sd1) *
                                  ($urandom_range(1, 4) << 16))
                               : 32'($signed($urandom_range(0, 65535)) - 32768);
            1: return $urandom();
            2: return 32'($signed($urandom_range(0, 1 << 19)) - (1 << 18));
            default: return '0;
        endcase
    endfunction

    // Loads one matrix of the given size in random order; kind 3 is all zero,
    // kind 4 copies row 0 into row 1 to make it singular.
    task automatic load_matrix(input int n, input int kind);
        logic [31:0] m[4][4];
        int          pos[$];
        int          tmp;
        int          k;
        logic [15:0] need;
        for (int r = 0; r < 4; r++)
            for (int c = 0; c < 4; c++)
                m[r][c] = pick_value(kind == 4 ? 2 : kind, r, c);
        if (kind == 4)
            for (int c = 0; c < 4; c++)
                m[1][c] = m[0][c];
        need = '0;
        for (int r = 0; r < n; r++)
            for (int c = 0; c < n; c++)
            begin
                need[r*4 + c] = 1'b1;
                pos.push_back(r*4 + c);
            end
        pos.shuffle();
        // With everything already written, sometimes only part of it is replaced.
        if ((need & ~written_mask) == 0 && kind != 4 && $urandom_range(0, 3) == 0)
            while (pos.size() > 1 && $urandom_range(0, 2) != 0)
                tmp = pos.pop_back();
        if (n < 4 && $urandom_range(0, 2) == 0)
        begin
            k = $urandom_range(n, 3);
            push_elem(k, $urandom_range(0, 3), $urandom(), 1'b0);
        end
        for (int i = 0; i < pos.size(); i++)
            push_elem(pos[i] / 4, pos[i] % 4, m[pos[i] / 4][pos[i] % 4],
                      i == pos.size() - 1);
    endtask

    task automatic drain();
        wait (load_q.size() == 0 && !s_tvalid && inverse_q.size() == 0);
        repeat (8) @(posedge clk);
    endtask

    task automatic set_size(input logic [2:0] v);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        size_reg   = v;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    initial
    begin
        int n;
        int kind;
        int phase;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        size_reg = 3'd4;
        written_mask = '0;
        fail_count = 0;
        req_count = 0;
        inv_count = 0;
        result_count = 0;
        singular_count = 0;
        sat_count = 0;
        idle_cycles = 0;
        calm = 1'b0;
        long_hold = 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: extremes, identity, zero matrix, an out-of-range size.
        set_size(3'd2);
        push_elem(0, 0, 32'h7FFF_FFFF, 1'b0);
        push_elem(0, 1, 32'h8000_0000, 1'b0);
        push_elem(1, 0, 32'h8000_0000, 1'b0);
        push_elem(1, 1, 32'h7FFF_FFFF, 1'b1);
        drain();
        set_size(3'd0);
        push_elem(0, 0, 32'h0001_0000, 1'b0);
        push_elem(1, 1, 32'h0001_0000, 1'b0);
        push_elem(0, 1, 32'h0, 1'b0);
        push_elem(1, 0, 32'h0, 1'b1);
        drain();
        load_matrix(2, 3);
        drain();
        set_size(3'd3);
        load_matrix(3, 0);
        drain();

        phase = 0;
        while (req_count < 380)
        begin
            set_size(3'($urandom_range(0, 7)));
            n = (size_reg < 2) ? 2 : (size_reg > 4) ? 4 : int'(size_reg);
            calm = ($urandom_range(0, 4) == 0);
            if (phase == 5)
                long_hold = 1'b1;
            // The long hold phase queues several matrices so the sender keeps offering.
            repeat ((phase == 5) ? 3 : $urandom_range(1, 3))
            begin
                kind = $urandom_range(0, 9);
                kind = (kind < 5) ? 0 : (kind < 7) ? 1 : (kind < 8) ? 2 : (kind < 9) ? 4 : 3;
                load_matrix(n, kind);
            end
            drain();
            phase++;
        end
        calm = 1'b0;
        wait (inverse_q.size() == 0);
        repeat (100) @(posedge clk);

        $display("%0d requests loaded, %0d inversions, %0d results checked",
                 req_count, inv_count, result_count);
        $display("%0d singular and %0d saturated results among them",
                 singular_count, sat_count);
        if (fail_count == 0 && inverse_q.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

/* filelist.f */
+incdir+rtl/core
rtl/core/smi_pkg.sv
rtl/core/small_matrix_inverse.sv
bench/tb_top.sv
